FILE: hw/rtl/prf_pkg.sv
// ----------------------------------------------------------------------------
// prf_pkg: shared types and constants for the page frame replacement unit
// Sizes, the token carried along the cell row, per-item control, commit bus.
// ----------------------------------------------------------------------------
package prf_pkg;

  localparam int FRAME_CNT = 8;
  localparam int PAGE_BITS = 16;
  localparam int AGE_BITS  = 16;

  // frame index width and active-count width (count may equal FRAME_CNT)
  localparam int IDX_W = (FRAME_CNT > 1) ? $clog2(FRAME_CNT) : 1;
  localparam int CNT_W = $clog2(FRAME_CNT + 1);

  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;
  localparam logic [31:0]         HIT_MAX = '1;

  typedef enum logic [0:0] {
    REG_REPLACE_MODE  = 1'b0,
    REG_FRAMES_IN_USE = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic                 valid;
    logic                 decided;   // empty frame filled or hit found
    logic                 hit;
    logic [IDX_W-1:0]     slot;      // decided frame, else victim candidate
    logic [AGE_BITS-1:0]  best_age;  // largest age seen so far (LRU)
    logic [PAGE_BITS-1:0] page;
    logic [PAGE_BITS-1:0] cand_page; // page held by the victim candidate
  } tok_t;

  // settings that the user must hold steady while an item is in flight; the block itself does not enforce this
  typedef struct packed {
    logic             lru;
    logic [CNT_W-1:0] n;
    logic [IDX_W-1:0] fifo_slot;
  } ctl_t;

  // replacement write into one frame
  typedef struct packed {
    logic                 en;
    logic [IDX_W-1:0]     slot;
    logic [PAGE_BITS-1:0] page;
  } commit_t;

endpackage

FILE: hw/rtl/prf_cell.sv
// ----------------------------------------------------------------------------
// prf_cell: one frame of the replacement row
// Holds page, valid and age; updates them as the search token passes or a
// replacement write names it, and hands the token on through a register.
// ----------------------------------------------------------------------------
module prf_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [prf_pkg::IDX_W-1:0] idx,
  input  prf_pkg::ctl_t     ctl,
  input  prf_pkg::commit_t  commit,
  input  prf_pkg::tok_t     tin,
  output prf_pkg::tok_t     tout
);
  import prf_pkg::*;

  logic                 valid_r, valid_nxt;
  logic [PAGE_BITS-1:0] page_r, page_nxt;
  logic [AGE_BITS-1:0]  age_r, age_nxt;
  logic [AGE_BITS-1:0]  age_inc;
  tok_t                 tout_r, tout_nxt;
  logic                 active;

  assign active  = CNT_W'(idx) < ctl.n;
  assign age_inc = (age_r == AGE_MAX) ? age_r : age_r + 1'b1;

  always_comb begin
    tout_nxt  = tin;
    valid_nxt = valid_r;
    page_nxt  = page_r;
    age_nxt   = age_r;
    if (tin.valid && active) begin
      age_nxt = age_inc;
      if (!tin.decided) begin
        if (!valid_r) begin
          valid_nxt        = 1'b1;
          page_nxt         = tin.page;
          age_nxt          = '0;
          tout_nxt.decided = 1'b1;
          tout_nxt.slot    = idx;
        end else if (page_r == tin.page) begin
          tout_nxt.hit     = 1'b1;
          tout_nxt.decided = 1'b1;
          tout_nxt.slot    = idx;
          if (ctl.lru) begin
            age_nxt = '0;
          end
        end else if (ctl.lru) begin
          // strict compare keeps the lowest index among equal ages
          if (age_inc > tin.best_age) begin
            tout_nxt.best_age  = age_inc;
            tout_nxt.slot      = idx;
            tout_nxt.cand_page = page_r;
          end
        end else if (idx == ctl.fifo_slot) begin
          tout_nxt.slot      = idx;
          tout_nxt.cand_page = page_r;
        end
      end
    end
    if (commit.en && commit.slot == idx) begin
      valid_nxt = 1'b1;
      page_nxt  = commit.page;
      age_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    page_r <= page_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
      age_r   <= '0;
      tout_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      age_r   <= age_nxt;
      tout_r  <= tout_nxt;
    end
  end

  assign tout = tout_r;

endmodule

FILE: hw/rtl/page_frame_replacement.sv
// Flow: an accepted beat is launched through the launch register, its search
//   token walks the row of frame cells one cell per cycle, is held at the
//   row's end and then waits until the output register is free (out_tready).
// Only one item is in flight: a new beat is taken only once the previous
//   result has gone into the output register.
// Reset (rst_n low, synchronous): all frames empty, ages, FIFO pointer and
//   hit count zero, FIFO mode, all 8 frames in use.
// ----------------------------------------------------------------------------
// page_frame_replacement: FIFO / LRU page frame replacement unit
// Control, configuration, result register and the row of frame cells.
// ----------------------------------------------------------------------------
module page_frame_replacement (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] page_number
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // [0] hit, [3:1] frame_index, [4] evicted_valid,
                                  // [20:5] evicted_page, [52:21] hit_total
);
  import prf_pkg::*;

  logic             mode_r;
  logic [3:0]       fiu_r;
  logic [IDX_W-1:0] fifo_ptr_r, fifo_ptr_nxt;
  logic [31:0]      hit_cnt_r, hit_cnt_nxt;
  state_t           state_r, state_nxt;
  tok_t             launch_r, launch_nxt;
  tok_t             hold_r;
  logic             out_valid_r, out_valid_nxt;
  logic [55:0]      out_data_r;

  ctl_t             ctl;
  commit_t          commit;
  tok_t             chain [FRAME_CNT+1];
  tok_t             last_tok;
  logic             in_accept;
  logic             fire;
  logic [CNT_W-1:0] slot_inc;

  // active frame count, clamped to 1..FRAME_CNT
  always_comb begin
    ctl.lru = mode_r;
    if (fiu_r == 4'd0) begin
      ctl.n = CNT_W'(1);
    end else if (32'(fiu_r) > 32'(FRAME_CNT)) begin
      ctl.n = CNT_W'(FRAME_CNT);
    end else begin
      ctl.n = CNT_W'(fiu_r);
    end
    ctl.fifo_slot = (CNT_W'(fifo_ptr_r) < ctl.n) ? fifo_ptr_r : '0;
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      fiu_r  <= 4'd8;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_REPLACE_MODE:  mode_r <= cfg_wdata[0];
        REG_FRAMES_IN_USE: fiu_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // row of frame cells
  assign chain[0] = launch_r;
  for (genvar g = 0; g < FRAME_CNT; g++) begin : g_cell
    prf_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .idx    (IDX_W'(g)),
      .ctl    (ctl),
      .commit (commit),
      .tin    (chain[g]),
      .tout   (chain[g+1])
    );
  end
  assign last_tok = chain[FRAME_CNT];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_tvalid) state_nxt = ST_RUN;
      ST_RUN:    if (last_tok.valid) state_nxt = ST_FINISH;
      ST_FINISH: if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    in_tready = 1'b0;
    fire      = 1'b0;
    case (state_r)
      ST_IDLE:   in_tready = 1'b1;
      ST_RUN:    ;
      ST_FINISH: fire = !out_valid_r || out_tready;
      default:   ;
    endcase
  end

  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    launch_nxt           = '0;
    launch_nxt.valid     = in_accept;
    launch_nxt.page      = PAGE_BITS'(in_tdata);
    launch_nxt.slot      = ctl.fifo_slot;
  end

  assign commit.en   = fire && !hold_r.decided;
  assign commit.slot = hold_r.slot;
  assign commit.page = hold_r.page;

  assign slot_inc = CNT_W'(hold_r.slot) + 1'b1;

  always_comb begin
    fifo_ptr_nxt = fifo_ptr_r;
    if (commit.en && !mode_r) begin
      fifo_ptr_nxt = (slot_inc < ctl.n) ? IDX_W'(slot_inc) : '0;
    end
    hit_cnt_nxt = hit_cnt_r;
    if (fire && hold_r.hit && hit_cnt_r != HIT_MAX) begin
      hit_cnt_nxt = hit_cnt_r + 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_RUN && last_tok.valid) begin
      hold_r <= last_tok;
    end
    if (fire) begin
      out_data_r <= {3'b000,
                     hit_cnt_nxt,
                     16'(hold_r.decided ? '0 : hold_r.cand_page),
                     !hold_r.decided,
                     3'(hold_r.slot),
                     hold_r.hit};
    end
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      launch_r    <= '0;
      fifo_ptr_r  <= '0;
      hit_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      launch_r    <= launch_nxt;
      fifo_ptr_r  <= fifo_ptr_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // no token may reach the end of the row unless an item is running
  a_tok_only_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    last_tok.valid |-> state_r == ST_RUN)
    else $error("search token left the cell row outside a run");

  // an accepted beat launches exactly one token on the next cycle
  a_launch: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> launch_r.valid && state_r == ST_RUN)
    else $error("accepted beat did not launch a token");

  // a hit never reports an eviction
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[0] |-> !out_data_r[4])
    else $error("result reports both hit and eviction");

  // the hit count never goes down
  a_hit_mono: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 hit_cnt_r >= $past(hit_cnt_r))
    else $error("hit counter decreased");

  // a replacement write happens only with a finished token held
  a_commit_finish: assert property (@(posedge clk) disable iff (!rst_n)
    commit.en |-> state_r == ST_FINISH && !hold_r.hit)
    else $error("frame replaced outside the finish step");

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: page frame replacement unit
// Feeds page references over the input stream and checks every result beat
// against a cycle-free predictor of the frame table. It covers FIFO and LRU
// replacement, frame counts 0, 1, 2, 3, 5, 8 and 15, and mode and count
// changes with pages held; both stream sides idle at random in most phases.
// ----------------------------------------------------------------------------
module testbench;
  import prf_pkg::*;

  localparam int STUCK_LIMIT = 1000;
  localparam int MAX_GAP     = 18;
  localparam int RAND_ITEMS  = 180;

  typedef struct packed {
    logic                 hit;
    logic [IDX_W-1:0]     frame;
    logic                 evicted;
    logic [PAGE_BITS-1:0] evicted_page;
    logic [31:0]          hit_total;
  } access_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [0:0]  cfg_index  = '0;
  logic [3:0]  cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;

  // frame table as the block should hold it
  logic [PAGE_BITS-1:0] tbl_page  [FRAME_CNT];
  logic                 tbl_valid [FRAME_CNT];
  logic [AGE_BITS-1:0]  tbl_age   [FRAME_CNT];
  int                   fifo_ptr;
  logic [31:0]          hit_count;
  logic                 lru_mode;
  logic [3:0]           frames_reg;

  access_result_t pending_results[$];
  int  mismatches   = 0;
  int  stuck_cycles = 0;
  bit  in_quiet     = 1'b0;
  bit  out_quiet    = 1'b0;

  page_frame_replacement DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  function automatic access_result_t reference_page(logic [PAGE_BITS-1:0] page);
    access_result_t res;
    int             n;
    int             slot;
    bit             decided;
    logic [AGE_BITS-1:0] best;
    res = '0;
    slot = 0;
    decided = 1'b0;
    if (frames_reg == 4'd0) n = 1;
    else if (int'(frames_reg) > FRAME_CNT) n = FRAME_CNT;
    else n = int'(frames_reg);

    for (int i = 0; i < n; i++)
      if (tbl_age[i] != AGE_MAX) tbl_age[i] = tbl_age[i] + 1'b1;

    for (int i = 0; i < n && !decided; i++) begin
      if (!tbl_valid[i]) begin
        tbl_valid[i] = 1'b1;
        tbl_page[i]  = page;
        tbl_age[i]   = '0;
        slot = i;
        decided = 1'b1;
      end else if (tbl_page[i] == page) begin
        if (lru_mode) tbl_age[i] = '0;
        if (hit_count != HIT_MAX) hit_count = hit_count + 1'b1;
        res.hit = 1'b1;
        slot = i;
        decided = 1'b1;
      end
    end

    if (!decided) begin
      if (!lru_mode) begin
        // pointer left past the end by a shrunk frame count restarts at 0
        slot = (fifo_ptr < n) ? fifo_ptr : 0;
        fifo_ptr = (slot + 1 < n) ? slot + 1 : 0;
      end else begin
        best = tbl_age[0];
        slot = 0;
        for (int i = 1; i < n; i++)
          if (tbl_age[i] > best) begin
            best = tbl_age[i];
            slot = i;
          end
      end
      res.evicted      = 1'b1;
      res.evicted_page = tbl_page[slot];
      tbl_page[slot]   = page;
      tbl_valid[slot]  = 1'b1;
      tbl_age[slot]    = '0;
    end
    res.frame     = slot[IDX_W-1:0];
    res.hit_total = hit_count;
    return res;
  endfunction

  function automatic int draw_gap(bit quiet);
    return quiet ? 0 : int'($urandom_range(0, MAX_GAP));
  endfunction

  task automatic send_page(logic [15:0] page);
    int gap;
    gap = draw_gap(in_quiet);
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= page;
    do @(posedge clk); while (!in_tready);
    pending_results = {pending_results, reference_page(page)};
  endtask

  // drop valid and let every outstanding result come back
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [3:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == REG_REPLACE_MODE) lru_mode = value[0];
    else frames_reg = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic check_result(logic [55:0] beat);
    access_result_t exp_res;
    access_result_t got;
    got.hit          = beat[0];
    got.frame        = beat[3:1];
    got.evicted      = beat[4];
    got.evicted_page = beat[20:5];
    got.hit_total    = beat[52:21];
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: result beat with nothing expected: %h", beat);
    end else begin
      exp_res = pending_results.pop_front();
      if (got.hit != exp_res.hit || got.frame != exp_res.frame ||
          got.evicted != exp_res.evicted || got.evicted_page != exp_res.evicted_page ||
          got.hit_total != exp_res.hit_total || beat[55:53] != 3'b000) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"ERROR: hit %0d/%0d frame %0d/%0d evicted %0d/%0d page %h/%h ",
                    "total %0d/%0d pad %b (exp/got)"},
                   exp_res.hit, got.hit, exp_res.frame, got.frame, exp_res.evicted,
                   got.evicted, exp_res.evicted_page, got.evicted_page,
                   exp_res.hit_total, got.hit_total, beat[55:53]);
      end
    end
  endtask

  // result side: random stall before each beat
  initial begin : result_sink
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = draw_gap(out_quiet);
      if (stall > 0) begin
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      check_result(out_tdata);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic test_fifo_fill();
    // defaults: FIFO, all frames; fill with field extremes, hit, then wrap
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'hAAAA);
    send_page(16'h5555);
    send_page(16'h0001);
    send_page(16'h0002);
    send_page(16'h0003);
    send_page(16'h0004);
    send_page(16'hFFFF);
    send_page(16'h0005);
    send_page(16'h0000);
    drain_results();
  endtask

  task automatic test_frame_count();
    // pointer sits at 2, so two frames leave it stale
    write_reg(REG_FRAMES_IN_USE, 4'd2);
    send_page(16'h0006);
    drain_results();
    write_reg(REG_FRAMES_IN_USE, 4'd0);
    send_page(16'h0007);
    send_page(16'h0007);
    drain_results();
    // above the built count; upper frames kept their pages meanwhile
    write_reg(REG_FRAMES_IN_USE, 4'd15);
    send_page(16'hAAAA);
    drain_results();
  endtask

  task automatic test_lru();
    write_reg(REG_REPLACE_MODE, 4'd1);
    write_reg(REG_FRAMES_IN_USE, 4'd8);
    send_page(16'h5555);
    send_page(16'h1234);
    send_page(16'h0001);
    send_page(16'h4321);
    send_page(16'h1234);
    send_page(16'h8000);
    drain_results();
    // policy change keeps the table
    write_reg(REG_REPLACE_MODE, 4'd0);
    send_page(16'h8001);
    drain_results();
  endtask

  task automatic test_random_phase(bit lru, logic [3:0] frames, bit quiet);
    int base;
    int span;
    logic [15:0] page;
    write_reg(REG_REPLACE_MODE, {3'b000, lru});
    write_reg(REG_FRAMES_IN_USE, frames);
    in_quiet  = quiet;
    out_quiet = quiet;
    base = int'($urandom_range(0, 65535));
    span = int'($urandom_range(1, 12));
    for (int k = 0; k < RAND_ITEMS; k++) begin
      // mostly a small working set so hits and evictions both occur
      if ($urandom_range(0, 7) == 0) page = 16'($urandom_range(0, 65535));
      else page = 16'(base + int'($urandom_range(0, span)));
      send_page(page);
    end
    drain_results();
    in_quiet  = 1'b0;
    out_quiet = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < FRAME_CNT; i++) begin
      tbl_page[i]  = '0;
      tbl_valid[i] = 1'b0;
      tbl_age[i]   = '0;
    end
    fifo_ptr   = 0;
    hit_count  = '0;
    lru_mode   = 1'b0;
    frames_reg = 4'd8;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    test_fifo_fill();
    test_frame_count();
    test_lru();
    test_random_phase(1'b0, 4'd8, 1'b0);
    test_random_phase(1'b1, 4'd8, 1'b0);
    test_random_phase(1'b0, 4'd1, 1'b1);
    test_random_phase(1'b1, 4'd1, 1'b0);
    test_random_phase(1'b1, 4'd0, 1'b0);
    test_random_phase(1'b0, 4'd15, 1'b0);
    test_random_phase(1'b1, 4'd3, 1'b1);
    test_random_phase(1'b0, 4'd5, 1'b0);
    test_random_phase(1'b1, 4'd8, 1'b0);

    drain_results();
    repeat (30) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/prf_pkg.sv
hw/rtl/prf_cell.sv
hw/rtl/page_frame_replacement.sv
test/testbench.sv
